/* design/nmdn_pkg.sv */
// shared types and constants for the normal map decode / normalize block
// no dependencies
package nmdn_pkg;

   localparam int CHAN_W   = 8;
   localparam int ENC_W    = 16;
   localparam int VEC_W    = 24;   // scaled component, signed
   localparam int SQ_W     = 46;   // one squared component
   localparam int SUM_W    = 48;   // squared length
   localparam int RAD_W    = 64;   // squared length shifted up by 16
   localparam int ROOT_W   = 32;
   localparam int SQ_STEPS = 32;
   localparam int NUM_W    = 48;   // 2*|v|*2^23 + r
   localparam int DEN_W    = 33;   // 2*r
   localparam int QUO_W    = 17;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [1:0] REG_NORMAL_SCALE = 2'd0;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
   localparam logic [1:0] REG_ZERO_THRESH = 2'd2;

   localparam logic signed [15:0] NORMAL_SCALE_RST = 16'sd4096;
   localparam logic [2:0]  CHANNEL_COUNT_RST = 3'd3;
   localparam logic [15:0] ZERO_THRESH_RST = 16'd17;

   localparam logic [16:0] THRESH_MULT = 17'd65025;   // 255^2
   localparam logic [ENC_W-1:0] ENC_HALF = 16'd32768;
   localparam logic [ENC_W-1:0] ENC_MAX  = 16'd65535;

   typedef struct packed {
      logic                    is_long;
      logic signed [VEC_W-1:0] vx;
      logic signed [VEC_W-1:0] vy;
      logic signed [VEC_W-1:0] vz;
   } side_type;

endpackage

/* design/nmdn_ifs.sv */
// valid/ready channel interfaces for texel transactions and normal results
// depends on nmdn_pkg
interface nmdn_req_if;
   import nmdn_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] first_channel;
   logic [CHAN_W-1:0] second_channel;
   logic [CHAN_W-1:0] third_channel;
   modport source (output valid, first_channel, second_channel, third_channel, input ready);
   modport sink (input valid, first_channel, second_channel, third_channel, output ready);
endinterface

interface nmdn_rsp_if;
   import nmdn_pkg::*;
   logic             valid;
   logic             ready;
   logic [ENC_W-1:0] normal_x_encoded;
   logic [ENC_W-1:0] normal_y_encoded;
   logic [ENC_W-1:0] normal_z_encoded;
   modport source (output valid, normal_x_encoded, normal_y_encoded, normal_z_encoded,
                   input ready);
   modport sink (input valid, normal_x_encoded, normal_y_encoded, normal_z_encoded,
                 output ready);
endinterface

/* design/normal_map_decode_normalize.sv */
// top level: register port, front end, square root, three dividers, encode/output stage
// depends on nmdn_pkg, nmdn_ifs, nmdn_front, nmdn_sqrt, nmdn_div
//
//  channel   direction  handshake             payload
//  req_chan  in         valid/ready           first/second/third_channel, 8 bits each
//  rsp_chan  out        valid/ready           normal_x/y/z_encoded, 16 bits each
//  apb       in         psel/penable/pwrite   paddr 4 bits, pwdata/prdata 32 bits
//
// one transaction per cycle while the output register is not held; 3 front stages, 32 square
// root stages, 1 divide setup and 17 divide stages, 1 output register
// the square root, one bit per stage over 32 stages, sets the depth
// reset is synchronous, clears all valid bits and loads the register defaults
// the whole pipeline holds while the output register is full and not taken;
// bubbles inside the pipeline move forward only when it advances
module normal_map_decode_normalize (
   input  logic                          clock,
   input  logic                          reset,
   nmdn_req_if.sink                      req_chan,
   nmdn_rsp_if.source                    rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [nmdn_pkg::ADDR_W-1:0]   paddr,
   input  logic [nmdn_pkg::DATA_W-1:0]   pwdata,
   output logic [nmdn_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import nmdn_pkg::*;

   // config registers
   logic signed [15:0] normal_scale_ff;
   logic [2:0]         channel_count_ff;
   logic [15:0]        zero_thresh_ff;
   logic               wr_en;
   logic [1:0]         reg_idx;

   // pipeline advance: move when the output register is empty or being taken
   logic adv;

   logic             fr_valid;
   logic [RAD_W-1:0] fr_rad;
   side_type         fr_side;

   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   side_type          sq_side;

   logic             dx_valid, dx_tag, dx_neg, dy_neg, dz_neg;
   logic [QUO_W-1:0] dx_quo, dy_quo, dz_quo;

   // output register
   logic             out_valid_ff, out_valid_in;
   logic [ENC_W-1:0] ox_ff, oy_ff, oz_ff;
   logic [ENC_W-1:0] ox_in, oy_in, oz_in;

   // ---------------------------------------------------------------- registers
   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_scale_ff  <= NORMAL_SCALE_RST;
         channel_count_ff <= CHANNEL_COUNT_RST;
         zero_thresh_ff   <= ZERO_THRESH_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_NORMAL_SCALE: begin
               normal_scale_ff <= $signed(pwdata[15:0]);
            end
            REG_CHANNEL_COUNT: begin
               channel_count_ff <= pwdata[2:0];
            end
            REG_ZERO_THRESH: begin
               zero_thresh_ff <= pwdata[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_NORMAL_SCALE:  prdata = {{16{normal_scale_ff[15]}}, normal_scale_ff};
         REG_CHANNEL_COUNT: prdata = {29'b0, channel_count_ff};
         REG_ZERO_THRESH:   prdata = {16'b0, zero_thresh_ff};
         default:           prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   assign adv           = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // channel select, decode to 2c-255, scale, squares and length compare
   nmdn_front u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (adv),
      .in_valid      (req_chan.valid),
      .in_c0         (req_chan.first_channel),
      .in_c1         (req_chan.second_channel),
      .in_c2         (req_chan.third_channel),
      .normal_scale  (normal_scale_ff),
      .channel_count (channel_count_ff),
      .zero_thresh   (zero_thresh_ff),
      .out_valid     (fr_valid),
      .out_rad       (fr_rad),
      .out_side      (fr_side)
   );

   // r = floor(sqrt(S * 2^16))
   nmdn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (fr_valid),
      .in_rad    (fr_rad),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // one divider per component; x carries valid and the long-vector flag
   nmdn_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_valid),
      .in_tag    (sq_side.is_long),
      .in_v      (sq_side.vx),
      .in_root   (sq_root),
      .out_valid (dx_valid),
      .out_tag   (dx_tag),
      .out_neg   (dx_neg),
      .out_quo   (dx_quo)
   );

   nmdn_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_valid),
      .in_tag    (sq_side.is_long),
      .in_v      (sq_side.vy),
      .in_root   (sq_root),
      .out_valid (),
      .out_tag   (),
      .out_neg   (dy_neg),
      .out_quo   (dy_quo)
   );

   nmdn_div u_div_z (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_valid),
      .in_tag    (sq_side.is_long),
      .in_v      (sq_side.vz),
      .in_root   (sq_root),
      .out_valid (),
      .out_tag   (),
      .out_neg   (dz_neg),
      .out_quo   (dz_quo)
   );

   // re-encode 32768 +/- q with clamp to 0..65535
   function automatic logic [ENC_W-1:0] enc_comp(input logic neg, input logic [QUO_W-1:0] q);
      logic signed [QUO_W+1:0] o;
      o = neg ? ($signed({2'b0, ENC_HALF}) - $signed({2'b0, q}))
              : ($signed({2'b0, ENC_HALF}) + $signed({2'b0, q}));
      if (o < 0) begin
         enc_comp = '0;
      end else if (o > $signed({2'b0, ENC_MAX})) begin
         enc_comp = ENC_MAX;
      end else begin
         enc_comp = o[ENC_W-1:0];
      end
   endfunction

   always_comb begin
      out_valid_in = dx_valid;
      if (dx_tag) begin
         ox_in = enc_comp(dx_neg, dx_quo);
         oy_in = enc_comp(dy_neg, dy_quo);
         oz_in = enc_comp(dz_neg, dz_quo);
      end else begin
         // short vector falls back to (0,0,1)
         ox_in = ENC_HALF;
         oy_in = ENC_HALF;
         oz_in = ENC_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ox_ff <= ox_in;
         oy_ff <= oy_in;
         oz_ff <= oz_in;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.normal_x_encoded = ox_ff;
   assign rsp_chan.normal_y_encoded = oy_ff;
   assign rsp_chan.normal_z_encoded = oz_ff;

endmodule

/* design/nmdn_front.sv */
// decode, scale, square and threshold compare, three register stages
// depends on nmdn_pkg
module nmdn_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [nmdn_pkg::CHAN_W-1:0]       in_c0,
   input  logic [nmdn_pkg::CHAN_W-1:0]       in_c1,
   input  logic [nmdn_pkg::CHAN_W-1:0]       in_c2,
   input  logic signed [15:0]                normal_scale,
   input  logic [2:0]                        channel_count,
   input  logic [15:0]                       zero_thresh,
   output logic                              out_valid,
   output logic [nmdn_pkg::RAD_W-1:0]        out_rad,
   output nmdn_pkg::side_type                out_side
);
   import nmdn_pkg::*;

   // stage 0
   logic                    v0_ff;
   logic signed [VEC_W-1:0] vx0_ff, vy0_ff, vz0_ff;
   logic signed [VEC_W-1:0] vx0_in, vy0_in, vz0_in;
   logic [CHAN_W-1:0]       c1_sel, c2_sel;
   logic signed [9:0]       ex, ey, ez;
   logic signed [25:0]      px, py;

   // stage 1
   logic              v1_ff;
   logic [SQ_W-1:0]   sx1_ff, sy1_ff, sz1_ff;
   logic [31:0]       thr1_ff;
   side_type          side1_ff;
   logic signed [47:0] qx, qy, qz;
   logic [32:0]       thr_prod;

   // stage 2
   logic              v2_ff;
   logic [RAD_W-1:0]  rad2_ff;
   side_type          side2_ff;
   logic [SUM_W-1:0]  sum;

   always_comb begin
      c1_sel = (channel_count > 3'd1) ? in_c1 : in_c0;
      c2_sel = (channel_count > 3'd2) ? in_c2 : in_c0;
      // 2c - 255
      ex = $signed({1'b0, in_c0, 1'b1}) - 10'sd256;
      ey = $signed({1'b0, c1_sel, 1'b1}) - 10'sd256;
      ez = $signed({1'b0, c2_sel, 1'b1}) - 10'sd256;
      px = ex * normal_scale;
      py = ey * normal_scale;
      vx0_in = px[VEC_W-1:0];
      vy0_in = py[VEC_W-1:0];
      vz0_in = {{3{ez[9]}}, ez[8:0], 12'b0};
   end

   always_comb begin
      qx = vx0_ff * vx0_ff;
      qy = vy0_ff * vy0_ff;
      qz = vz0_ff * vz0_ff;
      thr_prod = zero_thresh * THRESH_MULT;
   end

   assign sum = SUM_W'(sx1_ff) + SUM_W'(sy1_ff) + SUM_W'(sz1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vx0_ff <= vx0_in;
         vy0_ff <= vy0_in;
         vz0_ff <= vz0_in;
         sx1_ff <= qx[SQ_W-1:0];
         sy1_ff <= qy[SQ_W-1:0];
         sz1_ff <= qz[SQ_W-1:0];
         thr1_ff <= thr_prod[31:0];
         side1_ff.is_long <= 1'b0;
         side1_ff.vx <= vx0_ff;
         side1_ff.vy <= vy0_ff;
         side1_ff.vz <= vz0_ff;
         rad2_ff <= {sum, 16'b0};
         side2_ff.is_long <= (sum > SUM_W'(thr1_ff));
         side2_ff.vx <= side1_ff.vx;
         side2_ff.vy <= side1_ff.vy;
         side2_ff.vz <= side1_ff.vz;
      end
   end

   assign out_valid = v2_ff;
   assign out_rad   = rad2_ff;
   assign out_side  = side2_ff;

endmodule

/* design/nmdn_sqrt.sv */
// pipelined integer square root, one result bit per register stage
// depends on nmdn_pkg
module nmdn_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [nmdn_pkg::RAD_W-1:0]  in_rad,
   input  nmdn_pkg::side_type          in_side,
   output logic                        out_valid,
   output logic [nmdn_pkg::ROOT_W-1:0] out_root,
   output nmdn_pkg::side_type          out_side
);
   import nmdn_pkg::*;

   logic [RAD_W-1:0] n_ff    [0:SQ_STEPS-1];
   logic [RAD_W-1:0] res_ff  [0:SQ_STEPS-1];
   side_type         side_ff [0:SQ_STEPS-1];
   logic             valid_ff [0:SQ_STEPS-1];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
      logic [RAD_W-1:0] n_prev, res_prev, trial, n_in, res_in;
      side_type         side_prev;
      logic             valid_prev;

      if (k == 0) begin : g_first
         assign n_prev     = in_rad;
         assign res_prev   = '0;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign n_prev     = n_ff[k-1];
         assign res_prev   = res_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      always_comb begin
         trial = res_prev + BIT;
         if (n_prev >= trial) begin
            n_in   = n_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            n_in   = n_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k]    <= n_in;
            res_ff[k]  <= res_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[SQ_STEPS-1];
   assign out_root  = res_ff[SQ_STEPS-1][ROOT_W-1:0];
   assign out_side  = side_ff[SQ_STEPS-1];

endmodule

/* design/nmdn_div.sv */
// pipelined rounded divide |v|*2^23 / r, one quotient bit per register stage
// depends on nmdn_pkg
module nmdn_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic                              in_tag,
   input  logic signed [nmdn_pkg::VEC_W-1:0] in_v,
   input  logic [nmdn_pkg::ROOT_W-1:0]       in_root,
   output logic                              out_valid,
   output logic                              out_tag,
   output logic                              out_neg,
   output logic [nmdn_pkg::QUO_W-1:0]        out_quo
);
   import nmdn_pkg::*;

   // prep stage
   logic             pv_ff, ptag_ff, pneg_ff;
   logic [NUM_W-1:0] pnum_ff;
   logic [DEN_W-1:0] pden_ff;
   logic [VEC_W-1:0] mag;

   logic [NUM_W-1:0] rem_ff  [0:QUO_W-1];
   logic [DEN_W-1:0] den_ff  [0:QUO_W-1];
   logic [QUO_W-1:0] quo_ff  [0:QUO_W-1];
   logic             neg_ff  [0:QUO_W-1];
   logic             tag_ff  [0:QUO_W-1];
   logic             valid_ff [0:QUO_W-1];

   assign mag = in_v[VEC_W-1] ? VEC_W'(-in_v) : VEC_W'(in_v);

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= in_valid;
      end
   end

   // round half away: floor((2*mag*2^23 + r) / (2r))
   always_ff @(posedge clock) begin
      if (en) begin
         ptag_ff <= in_tag;
         pneg_ff <= in_v[VEC_W-1];
         pnum_ff <= {mag, 24'b0} + NUM_W'(in_root);
         pden_ff <= {in_root, 1'b0};
      end
   end

   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      localparam int SH = QUO_W - 1 - i;
      logic [NUM_W-1:0] rem_prev, rem_in;
      logic [DEN_W-1:0] den_prev;
      logic [QUO_W-1:0] quo_prev, quo_in;
      logic             neg_prev, tag_prev, valid_prev;
      logic [NUM_W:0]   dsh;

      if (i == 0) begin : g_first
         assign rem_prev   = pnum_ff;
         assign den_prev   = pden_ff;
         assign quo_prev   = '0;
         assign neg_prev   = pneg_ff;
         assign tag_prev   = ptag_ff;
         assign valid_prev = pv_ff;
      end else begin : g_next
         assign rem_prev   = rem_ff[i-1];
         assign den_prev   = den_ff[i-1];
         assign quo_prev   = quo_ff[i-1];
         assign neg_prev   = neg_ff[i-1];
         assign tag_prev   = tag_ff[i-1];
         assign valid_prev = valid_ff[i-1];
      end

      always_comb begin
         dsh = (NUM_W+1)'(den_prev) << SH;
         if ({1'b0, rem_prev} >= dsh) begin
            rem_in = rem_prev - dsh[NUM_W-1:0];
            quo_in = quo_prev | (QUO_W'(1) << SH);
         end else begin
            rem_in = rem_prev;
            quo_in = quo_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            den_ff[i] <= den_prev;
            quo_ff[i] <= quo_in;
            neg_ff[i] <= neg_prev;
            tag_ff[i] <= tag_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_tag   = tag_ff[QUO_W-1];
   assign out_neg   = neg_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];

endmodule
